FILE: rtl/core/teg_pkg.sv
// Shared constants and types for the tone-envelope signal generator.
package teg_pkg;

    // Configuration register index, taken from paddr[4:2]
    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_AMPLITUDE      = 3'd0;
    localparam t_reg_idx REG_MOD_DEPTH      = 3'd1;
    localparam t_reg_idx REG_ENVELOPE_STEP  = 3'd2;
    localparam t_reg_idx REG_CARRIER_STEP   = 3'd3;
    localparam t_reg_idx REG_CARRIER_OFFSET = 3'd4;
    localparam t_reg_idx REG_SAMPLE_COUNT   = 3'd5;

    // Register reset values
    localparam logic [15:0] AMPLITUDE_RESET = 16'd16384;
    localparam logic [15:0] MOD_DEPTH_RESET = 16'd8192;
    localparam logic [31:0] COUNT_RESET     = 32'd1024;

    // Output sample width and fixed-point layout of the product chain
    localparam int SAMPLE_W  = 19;
    localparam int FRAC_BITS = 44;   // m*c1*c2 is Q44
    localparam int MUL_A_W   = 49;   // holds m*c1*c2 + 1.0 in Q44
    localparam int MUL_B_W   = 17;   // holds m zero-extended, or c2 or a sign-extended
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;

    // Cosine table generation: pi/2 and 1.0 in Q30
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

endpackage

FILE: rtl/core/tone_envelope_signal_generator.sv
// Tone-envelope signal generator: DDS amplitude-modulated tone, at most one sample per request.
//
// Each input request ticks the generator once; a request with restart set begins a new run at
// sample index 1 with both phase accumulators reloaded. While a run lasts each tick yields one
// sample floor(a * (1 + m*cos(env)*cos(car))) and its last flag; ticks outside a run, or with
// the run finished, yield nothing. A request that yields a sample passes the accepting
// state, a run check that also addresses the envelope cosine, a state that addresses the
// carrier cosine through the same registered table port, and the product steps m*c1, *c2
// and *a on one shared 49x17 signed multiplier, the first of which also takes the carrier
// value. The input is ready again once back in idle; a request that yields nothing returns
// there from the run check. The finished sample sits in an output register, so the next
// request is taken while it waits; the block stalls only when a second sample is ready
// before the first has been taken. The user must write configuration over the APB-style
// port only while no request is being worked on; the block does not enforce this.
module tone_envelope_signal_generator #(
    parameter int PHASE_BITS     = 32,
    parameter int COS_TABLE_BITS = 10,
    parameter int COUNT_BITS     = 24
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input requests
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_restart,
    // output samples
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [teg_pkg::SAMPLE_W-1:0] o_sample,
    output logic                          o_last
);

    localparam int ROM_N    = 1 << COS_TABLE_BITS;
    localparam int ADDR_W   = COS_TABLE_BITS + 1;
    localparam int TOP_W    = COS_TABLE_BITS + 2;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_ENV   = 3'd2;
    localparam logic [2:0] S_CAR   = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_MUL3  = 3'd5;

    typedef logic [14:0] t_rom [0:ROM_N];

    // Quarter-wave cosine table, unsigned Q0.15, built at elaboration from a Taylor series in Q30
    function automatic t_rom f_build_rom();
        t_rom                rom;
        logic [63:0]         x;
        logic [63:0]         x2;
        logic [63:0]         t;
        logic signed [63:0]  sum;
        logic [63:0]         r;
        for (int k = 0; k <= ROM_N; k++) begin
            x   = (64'(k) * teg_pkg::HALF_PI_Q30) >> COS_TABLE_BITS;
            x2  = (x * x) >> 30;
            t   = teg_pkg::ONE_Q30;
            sum = $signed(teg_pkg::ONE_Q30);
            t = ((t * x2) >> 30) / 2;   sum = sum - $signed(t);
            t = ((t * x2) >> 30) / 12;  sum = sum + $signed(t);
            t = ((t * x2) >> 30) / 30;  sum = sum - $signed(t);
            t = ((t * x2) >> 30) / 56;  sum = sum + $signed(t);
            t = ((t * x2) >> 30) / 90;  sum = sum - $signed(t);
            t = ((t * x2) >> 30) / 132; sum = sum + $signed(t);
            t = ((t * x2) >> 30) / 182; sum = sum - $signed(t);
            t = ((t * x2) >> 30) / 240; sum = sum + $signed(t);
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > $signed(teg_pkg::ONE_Q30)) begin
                sum = $signed(teg_pkg::ONE_Q30);
            end
            r = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
            rom[k] = 15'(r);
        end
        return rom;
    endfunction

    localparam t_rom COS_ROM = f_build_rom();

    // Scale a 32-bit phase register to the accumulator width
    function automatic logic [PHASE_BITS-1:0] f_scale(input logic [31:0] v);
        logic [79:0] w;
        w = {v, 48'd0};
        return w[79 -: PHASE_BITS];
    endfunction

    // Table address and negate flag for one phase: mirror in quadrants 1 and 3,
    // negate in quadrants 1 and 2
    function automatic logic [ADDR_W:0] f_lookup(input logic [PHASE_BITS-1:0] ph);
        logic [TOP_W-1:0]  top;
        logic [1:0]        quad;
        logic [ADDR_W-1:0] j;
        logic [ADDR_W-1:0] addr;
        top  = ph[PHASE_BITS-1 -: TOP_W];
        quad = top[TOP_W-1 -: 2];
        j    = {1'b0, top[COS_TABLE_BITS-1:0]};
        addr = (quad[0]) ? (ADDR_W'(ROM_N) - j) : j;
        return {quad[1] ^ quad[0], addr};
    endfunction

    // Configuration registers
    logic signed [15:0]     r_amplitude;
    logic [15:0]            r_mod_depth;
    logic [31:0]            r_envelope_step;
    logic [31:0]            r_carrier_step;
    logic [31:0]            r_carrier_offset;
    logic [COUNT_BITS-1:0]  r_sample_count;

    // Run state
    logic [2:0]             r_state, n_state;
    logic [PHASE_BITS-1:0]  r_envelope_phase, n_envelope_phase;
    logic [PHASE_BITS-1:0]  r_carrier_phase, n_carrier_phase;
    logic [COUNT_BITS-1:0]  r_sample_index, n_sample_index;
    logic                   r_running, n_running;

    // Datapath
    logic [ADDR_W:0]        lookup;
    logic [14:0]            r_rom_q;
    logic                   r_neg;
    logic signed [15:0]     cos_val;
    logic signed [15:0]     r_c1;
    logic signed [15:0]     r_c2;
    logic signed [teg_pkg::MUL_A_W-1:0] r_acc;
    logic signed [teg_pkg::MUL_A_W-1:0] mul_a;
    logic signed [teg_pkg::MUL_B_W-1:0] mul_b;
    logic signed [teg_pkg::MUL_P_W-1:0] mul_p;

    // Output register
    logic                   r_out_valid, n_out_valid;
    logic signed [teg_pkg::SAMPLE_W-1:0] r_sample;
    logic                   r_last;

    logic                   cfg_wr;
    logic                   out_free;
    logic                   is_last;
    teg_pkg::t_reg_idx      reg_idx;

    assign pready      = 1'b1;
    assign reg_idx     = paddr[4:2];
    assign cfg_wr      = psel & penable & pwrite;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_last      = r_last;
    assign out_free    = !r_out_valid || i_out_ready;
    assign is_last     = (r_sample_index == r_sample_count);

    // Register read-back
    always_comb begin
        case (reg_idx)
            teg_pkg::REG_AMPLITUDE:      prdata = {16'd0, r_amplitude};
            teg_pkg::REG_MOD_DEPTH:      prdata = {16'd0, r_mod_depth};
            teg_pkg::REG_ENVELOPE_STEP:  prdata = r_envelope_step;
            teg_pkg::REG_CARRIER_STEP:   prdata = r_carrier_step;
            teg_pkg::REG_CARRIER_OFFSET: prdata = r_carrier_offset;
            teg_pkg::REG_SAMPLE_COUNT:   prdata = 32'(r_sample_count);
            default:                     prdata = 32'd0;
        endcase
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amplitude      <= teg_pkg::AMPLITUDE_RESET;
            r_mod_depth      <= teg_pkg::MOD_DEPTH_RESET;
            r_envelope_step  <= 32'd0;
            r_carrier_step   <= 32'd0;
            r_carrier_offset <= 32'd0;
            r_sample_count   <= COUNT_BITS'(teg_pkg::COUNT_RESET);
        end else if (cfg_wr) begin
            case (reg_idx)
                teg_pkg::REG_AMPLITUDE:      r_amplitude      <= pwdata[15:0];
                teg_pkg::REG_MOD_DEPTH:      r_mod_depth      <= pwdata[15:0];
                teg_pkg::REG_ENVELOPE_STEP:  r_envelope_step  <= pwdata;
                teg_pkg::REG_CARRIER_STEP:   r_carrier_step   <= pwdata;
                teg_pkg::REG_CARRIER_OFFSET: r_carrier_offset <= pwdata;
                teg_pkg::REG_SAMPLE_COUNT:   r_sample_count   <= pwdata[COUNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Table port: envelope address in CHECK, carrier address in ENV
    assign lookup  = (r_state == S_CHECK) ? f_lookup(r_envelope_phase)
                                          : f_lookup(r_carrier_phase);
    assign cos_val = r_neg ? -$signed({1'b0, r_rom_q}) : $signed({1'b0, r_rom_q});

    always_ff @(posedge i_clk) begin
        r_rom_q <= COS_ROM[lookup[ADDR_W-1:0]];
        r_neg   <= lookup[ADDR_W];
    end

    // Shared multiplier: m*c1, then *c2, then *a
    always_comb begin
        case (r_state)
            S_CAR: begin
                mul_a = teg_pkg::MUL_A_W'(r_c1);
                mul_b = $signed({1'b0, r_mod_depth});
            end
            S_MUL2: begin
                mul_a = r_acc;
                mul_b = teg_pkg::MUL_B_W'(r_c2);
            end
            default: begin
                mul_a = r_acc;
                mul_b = teg_pkg::MUL_B_W'(r_amplitude);
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_ff @(posedge i_clk) begin
        if (r_state == S_ENV) begin
            r_c1 <= cos_val;
        end
        if (r_state == S_CAR) begin
            r_c2  <= cos_val;
            r_acc <= mul_p[teg_pkg::MUL_A_W-1:0];
        end
        if (r_state == S_MUL2) begin
            // add 1.0 in Q44
            r_acc <= mul_p[teg_pkg::MUL_A_W-1:0]
                     + (teg_pkg::MUL_A_W'(1) <<< teg_pkg::FRAC_BITS);
        end
        if (r_state == S_MUL3 && out_free) begin
            // floor division by 2^44 is the arithmetic shift
            r_sample <= mul_p[teg_pkg::FRAC_BITS +: teg_pkg::SAMPLE_W];
            r_last   <= is_last;
        end
    end

    // Sequencer
    always_comb begin
        n_state          = r_state;
        n_envelope_phase = r_envelope_phase;
        n_carrier_phase  = r_carrier_phase;
        n_sample_index   = r_sample_index;
        n_running        = r_running;
        n_out_valid      = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_CHECK;
                    if (i_restart) begin
                        n_envelope_phase = f_scale(r_envelope_step);
                        n_carrier_phase  = f_scale(r_carrier_offset)
                                           + f_scale(r_carrier_step);
                        n_sample_index   = COUNT_BITS'(1);
                        n_running        = 1'b1;
                    end
                end
            end
            S_CHECK: begin
                if (!r_running) begin
                    n_state = S_IDLE;
                end else if (r_sample_index > r_sample_count) begin
                    n_running = 1'b0;
                    n_state   = S_IDLE;
                end else begin
                    n_state = S_ENV;
                end
            end
            S_ENV:  n_state = S_CAR;
            S_CAR:  n_state = S_MUL2;
            S_MUL2: n_state = S_MUL3;
            S_MUL3: begin
                if (out_free) begin
                    n_out_valid      = 1'b1;
                    n_envelope_phase = r_envelope_phase + f_scale(r_envelope_step);
                    n_carrier_phase  = r_carrier_phase + f_scale(r_carrier_step);
                    if (is_last) begin
                        n_running = 1'b0;
                    end else begin
                        n_sample_index = r_sample_index + COUNT_BITS'(1);
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= S_IDLE;
            r_envelope_phase <= '0;
            r_carrier_phase  <= '0;
            r_sample_index   <= '0;
            r_running        <= 1'b0;
            r_out_valid      <= 1'b0;
        end else begin
            r_state          <= n_state;
            r_envelope_phase <= n_envelope_phase;
            r_carrier_phase  <= n_carrier_phase;
            r_sample_index   <= n_sample_index;
            r_running        <= n_running;
            r_out_valid      <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // An accepted request always goes to the run check next
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_CHECK))
        else $error("request accepted but run check skipped");

    // A live run never holds index zero
    a_index_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_running |-> (r_sample_index != '0))
        else $error("running with zero sample index");

    // A new sample appears only out of the final product step
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid ##1 r_out_valid) |-> ($past(r_state) == S_MUL3))
        else $error("output valid raised outside final product step");

    // Carrier read always follows the envelope read
    a_car_after_env: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CAR) |-> ($past(r_state) == S_ENV))
        else $error("carrier step without envelope read");
`endif

endmodule
